>>> design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and field layout for the bounded deque with delete by value
// ----------------------------------------------------------------------------
package bdq_pkg;

	// input beat fields
	localparam int OP_W  = 4;
	localparam int VAL_W = 32;
	localparam int CNT_W = 7;

	// result beat fields
	localparam int STAT_W = 3;
	localparam int OCC_W  = 7;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	localparam int S_USED_W   = OP_W + VAL_W + CNT_W;
	localparam int M_USED_W   = STAT_W + VAL_W + OCC_W;
	localparam int M_DATA_LSB = STAT_W;
	localparam int M_OCC_LSB  = STAT_W + VAL_W;

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD   = 4'd0,
		OP_INS_TAIL   = 4'd1,
		OP_DEL_HEAD   = 4'd2,
		OP_DEL_TAIL   = 4'd3,
		OP_DEL_HEAD_N = 4'd4,
		OP_DEL_TAIL_N = 4'd5,
		OP_PEEK_HEAD  = 4'd6,
		OP_PEEK_TAIL  = 4'd7,
		OP_DEL_VALUE  = 4'd8
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_NOT_FOUND = 3'd2,
		STAT_COUNT     = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PEEK,
		ST_SCAN,
		ST_SHIFT,
		ST_OUT
	} state_t;

endpackage

>>> design/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [bdq_pkg::VAL_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [bdq_pkg::VAL_W-1:0] rdata
);
	import bdq_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read before write on the same address
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> design/bounded_deque_with_value_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// double-ended queue of up to DEPTH signed 32-bit values in a circular store
// ----------------------------------------------------------------------------
// flow: insert, delete at an end and bulk delete pass from accept straight to
//   the result stage, peek reads the entry first (not on an empty queue), and
//   delete by value scans from the head, then shifts the later entries up
// throughput: one item at a time; delete by value walks the store one entry a
//   cycle through the single read port of the entry memory
// reset: head slot and occupancy clear at once, no clearing pass of the store
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// operation [3:0], value [35:4], count [42:36], zero fill [47:43]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,
	// status [2:0], data [34:3], occupancy [41:35], zero fill [47:42]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bdq_pkg::M_TDATA_W-1:0] m_tdata
);
	import bdq_pkg::*;

	localparam int IW = $clog2(DEPTH);        // slot index
	localparam int CW = $clog2(DEPTH + 1);    // occupancy and position
	localparam int SW = IW + 1;               // slot sum before wrap
	localparam int KW = (CW > CNT_W) ? CW : CNT_W;

	// slot of a position counted from the head; base + off stays below 2*DEPTH
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
		input logic [SW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + off;
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	// control state
	state_t        state_q, state_d;
	logic [IW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;

	// per-item working registers
	logic [CW-1:0]    pos_q, pos_d;       // position whose entry arrives this cycle
	logic [VAL_W-1:0] key_q, key_d;
	status_t          res_status_q, res_status_d;
	logic [VAL_W-1:0] res_data_q, res_data_d;

	// output register
	logic             m_tvalid_q;
	status_t          m_status_q;
	logic [VAL_W-1:0] m_data_q;
	logic [OCC_W-1:0] m_occ_q;
	logic             out_ld;

	// memory ports
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic [IW-1:0]    mem_raddr;
	logic [VAL_W-1:0] rd_data;

	// input beat fields
	op_t              in_op;
	logic [VAL_W-1:0] in_val;
	logic [CNT_W-1:0] in_cnt;
	logic             accept;

	logic          empty, full, cnt_big, match, last, out_free;
	logic [CW-1:0] pos_nx;

	assign in_op  = op_t'(s_tdata[OP_W-1:0]);
	assign in_val = s_tdata[OP_W +: VAL_W];
	assign in_cnt = s_tdata[OP_W + VAL_W +: CNT_W];
	assign accept = s_tvalid && s_tready;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign cnt_big  = (KW'(in_cnt) > KW'(count_q));
	assign pos_nx   = pos_q + CW'(1);
	assign last     = (pos_nx == count_q);
	assign match    = (rd_data == key_q);
	assign out_free = !m_tvalid_q || m_tready;

	bdq_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_PEEK_HEAD, OP_PEEK_TAIL: state_d = empty ? ST_OUT : ST_PEEK;
						OP_DEL_VALUE:               state_d = empty ? ST_OUT : ST_SCAN;
						default:                    state_d = ST_OUT;
					endcase
				end
			end
			ST_PEEK: state_d = ST_OUT;
			ST_SCAN: begin
				if (last) begin
					state_d = ST_OUT;
				end else if (match) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control and memory ports
	always_comb begin
		s_tready     = 1'b0;
		out_ld       = 1'b0;
		front_d      = front_q;
		count_d      = count_q;
		pos_d        = pos_q;
		key_d        = key_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		mem_we       = 1'b0;
		// during the shift an entry moves up one place, towards the head
		mem_waddr    = slot_of(front_q, SW'(pos_q) - SW'(1));
		mem_wdata    = rd_data;
		// the walk always fetches the position after the one arriving
		mem_raddr    = slot_of(front_q, SW'(pos_nx));

		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				mem_raddr = front_q;
				if (accept) begin
					key_d        = in_val;
					pos_d        = '0;
					res_status_d = STAT_OK;
					res_data_d   = '0;
					case (in_op)
						OP_INS_HEAD: begin
							if (full) begin
								res_status_d = STAT_FULL;
							end else begin
								front_d   = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
								mem_we    = 1'b1;
								mem_waddr = front_d;
								mem_wdata = in_val;
								count_d   = count_q + CW'(1);
							end
						end
						OP_INS_TAIL: begin
							if (full) begin
								res_status_d = STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = slot_of(front_q, SW'(count_q));
								mem_wdata = in_val;
								count_d   = count_q + CW'(1);
							end
						end
						OP_DEL_HEAD: begin
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end else begin
								front_d = slot_of(front_q, SW'(1));
								count_d = count_q - CW'(1);
							end
						end
						OP_DEL_TAIL: begin
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						OP_DEL_HEAD_N: begin
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end else if (cnt_big) begin
								res_status_d = STAT_COUNT;
							end else begin
								front_d = slot_of(front_q, SW'(in_cnt));
								count_d = count_q - CW'(in_cnt);
							end
						end
						OP_DEL_TAIL_N: begin
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end else if (cnt_big) begin
								res_status_d = STAT_COUNT;
							end else begin
								count_d = count_q - CW'(in_cnt);
							end
						end
						OP_PEEK_HEAD, OP_DEL_VALUE: begin
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end
						end
						OP_PEEK_TAIL: begin
							mem_raddr = slot_of(front_q, SW'(count_q - CW'(1)));
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PEEK: begin
				res_data_d = rd_data;
			end
			ST_SCAN: begin
				if (match) begin
					// a hit on the tail entry needs no shift
					if (last) begin
						count_d = count_q - CW'(1);
					end else begin
						pos_d = pos_nx;
					end
				end else if (last) begin
					res_status_d = STAT_NOT_FOUND;
				end else begin
					pos_d = pos_nx;
				end
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				if (last) begin
					count_d = count_q - CW'(1);
				end else begin
					pos_d = pos_nx;
				end
			end
			ST_OUT: begin
				out_ld = out_free;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		key_q        <= key_d;
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		if (out_ld) begin
			m_status_q <= res_status_q;
			m_data_q   <= res_data_q;
			// occupancy is final once the item reaches the result stage
			m_occ_q    <= OCC_W'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, m_occ_q, m_data_q, m_status_q};

endmodule

>>> design/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks on the deque's beats, bound to the top level
// ----------------------------------------------------------------------------
module bdq_checker #(
	parameter int DEPTH = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bdq_pkg::M_TDATA_W-1:0] m_tdata
);
	import bdq_pkg::*;

	logic [STAT_W-1:0] status_f;
	logic [VAL_W-1:0]  data_f;
	logic [OCC_W-1:0]  occ_f;

	assign status_f = m_tdata[STAT_W-1:0];
	assign data_f   = m_tdata[M_DATA_LSB +: VAL_W];
	assign occ_f    = m_tdata[M_OCC_LSB +: OCC_W];

	// one item in flight: no second beat right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted in back-to-back cycles");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> status_f <= STAT_FULL)
		else $error("status code out of range");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_f != STAT_OK |-> data_f == '0)
		else $error("data not zero on a failed operation");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (DEPTH > 127) || (int'(occ_f) <= DEPTH))
		else $error("occupancy above depth");

endmodule

bind bounded_deque_with_value_delete bdq_checker #(
	.DEPTH (DEPTH)
) u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bounded deque with delete by value: a short
// table of directed beats, then phased random traffic (fill, drain, search,
// mixed) checked against an in-bench model of the deque, with random gaps on
// the input side and random back-pressure on the result side
// ----------------------------------------------------------------------------
module testbench;

	import bdq_pkg::*;

	localparam int DEPTH        = 64;
	localparam int SLOT_W       = $clog2(DEPTH);
	localparam int RANDOM_ITEMS = 500;
	localparam int CALM_ITEMS   = 60;

	// codes the block ignores
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SEARCH} traffic_mode_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  data;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic             typed_in;   // expectation written in the row itself
		deque_result_t    want;
	} stim_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b1;
	logic [M_TDATA_W-1:0] m_tdata;

	// in-bench copy of the deque
	logic [VAL_W-1:0]  deque_store [DEPTH];
	logic [SLOT_W-1:0] head_slot  = '0;
	int                fill_level = 0;

	deque_result_t pending_results [$];
	int            error_count = 0;
	logic          quiet_tail  = 1'b0;   // no idling on either side once set

	// directed beats; rows with typed_in clear are checked against the model
	stim_row_t directed_rows [24] = '{
		// empty queue: every read or delete reports empty, bulk too
		'{OP_PEEK_HEAD,  32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_PEEK_TAIL,  32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_DEL_HEAD,   32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_DEL_TAIL,   32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_DEL_HEAD_N, 32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_DEL_TAIL_N, 32'hFFFF_FFFF, 7'd64, 1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_DEL_VALUE,  32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		// unused code: plain ok with the current size
		'{OP_SPARE_HI,   32'hFFFF_FFFF, 7'd127,1'b1, '{STAT_OK,        32'h0, 7'd0}},
		// extremes of the value range at both ends
		'{OP_INS_HEAD,   32'h7FFF_FFFF, 7'd0,  1'b1, '{STAT_OK,        32'h0, 7'd1}},
		'{OP_INS_TAIL,   32'h8000_0000, 7'd0,  1'b1, '{STAT_OK,        32'h0, 7'd2}},
		'{OP_PEEK_HEAD,  32'h0000_0000, 7'd0,  1'b1, '{STAT_OK, 32'h7FFF_FFFF, 7'd2}},
		'{OP_PEEK_TAIL,  32'h0000_0000, 7'd0,  1'b1, '{STAT_OK, 32'h8000_0000, 7'd2}},
		'{OP_INS_HEAD,   32'hFFFF_FFFF, 7'd0,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		// search misses, then a hit in the middle closes the gap
		'{OP_DEL_VALUE,  32'h0000_0005, 7'd0,  1'b1, '{STAT_NOT_FOUND, 32'h0, 7'd3}},
		'{OP_DEL_VALUE,  32'h7FFF_FFFF, 7'd0,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		'{OP_PEEK_TAIL,  32'h0000_0000, 7'd0,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		// bulk delete: too many, then zero on a non-empty queue
		'{OP_DEL_HEAD_N, 32'h0000_0000, 7'd3,  1'b1, '{STAT_COUNT,     32'h0, 7'd2}},
		'{OP_DEL_TAIL_N, 32'h0000_0000, 7'd0,  1'b1, '{STAT_OK,        32'h0, 7'd2}},
		'{OP_INS_TAIL,   32'h0000_0000, 7'd0,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		'{OP_DEL_TAIL_N, 32'h0000_0000, 7'd2,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		'{OP_DEL_HEAD,   32'h0000_0000, 7'd0,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		'{OP_DEL_TAIL,   32'h0000_0000, 7'd0,  1'b1, '{STAT_EMPTY,     32'h0, 7'd0}},
		'{OP_INS_TAIL,   32'h0000_0001, 7'd0,  1'b0, '{STAT_OK,        32'h0, 7'd0}},
		'{OP_DEL_HEAD_N, 32'h0000_0000, 7'd1,  1'b0, '{STAT_OK,        32'h0, 7'd0}}
	};

	bounded_deque_with_value_delete #(
		.DEPTH(DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #10 clk = ~clk;

	// slot of the entry at a given distance from the head, wraps with the store
	function automatic logic [SLOT_W-1:0] slot_at(input int pos);
		return head_slot + SLOT_W'(pos);
	endfunction

	// apply one operation to the in-bench deque and work out its result beat
	task automatic deque_apply(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
			input logic [CNT_W-1:0] count, output deque_result_t res);
		int hit;
		res = '{STAT_OK, '0, '0};
		hit = -1;
		case (op)
			OP_INS_HEAD, OP_INS_TAIL: begin
				if (fill_level >= DEPTH) begin
					res.status = STAT_FULL;
				end else if (op == OP_INS_HEAD) begin
					head_slot = head_slot - SLOT_W'(1);
					deque_store[head_slot] = value;
					fill_level++;
				end else begin
					deque_store[slot_at(fill_level)] = value;
					fill_level++;
				end
			end
			OP_DEL_HEAD, OP_DEL_TAIL: begin
				if (fill_level == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					if (op == OP_DEL_HEAD)
						head_slot = head_slot + SLOT_W'(1);
					fill_level--;
				end
			end
			OP_DEL_HEAD_N, OP_DEL_TAIL_N: begin
				// empty wins over a bad count, even for a count of zero
				if (fill_level == 0) begin
					res.status = STAT_EMPTY;
				end else if (int'(count) > fill_level) begin
					res.status = STAT_COUNT;
				end else begin
					if (op == OP_DEL_HEAD_N)
						head_slot = head_slot + SLOT_W'(count);
					fill_level -= int'(count);
				end
			end
			OP_PEEK_HEAD, OP_PEEK_TAIL: begin
				if (fill_level == 0)
					res.status = STAT_EMPTY;
				else
					res.data = deque_store[slot_at(op == OP_PEEK_HEAD ? 0 : fill_level - 1)];
			end
			OP_DEL_VALUE: begin
				if (fill_level == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					// first match counted from the head
					for (int i = 0; i < fill_level; i++)
						if (hit < 0 && deque_store[slot_at(i)] == value)
							hit = i;
					if (hit < 0) begin
						res.status = STAT_NOT_FOUND;
					end else begin
						// later entries move up one place towards the head
						for (int i = hit; i + 1 < fill_level; i++)
							deque_store[slot_at(i)] = deque_store[slot_at(i + 1)];
						fill_level--;
					end
				end
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(fill_level);
	endtask

	task automatic note_fault(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch at %0t ns: %s", $realtime, msg);
	endtask

	// present one beat and hold it until taken; handshake is judged from the
	// levels seen at the falling edge, which hold up to the next rising edge
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
			input logic [CNT_W-1:0] count, input logic typed_in, input deque_result_t typed_want);
		deque_result_t model_want;
		logic taken;
		s_tdata  <= {{(S_TDATA_W - S_USED_W){1'b0}}, count, value, op};
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		deque_apply(op, value, count, model_want);
		pending_results.push_back(typed_in ? typed_want : model_want);
	endtask

	// sender gap: valid drops for the length that the caller asks
	task automatic hold_off(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender waits until every result beat has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// result side: random stall bursts between stretches of steady ready
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_tready <= 1'b1;
				repeat ($urandom_range(0, 30)) @(posedge clk);
			end
		end
	end

	// result checker, sampled at the falling edge ahead of the accepting edge
	always @(negedge clk) begin : result_check
		deque_result_t got;
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status    = m_tdata[STAT_W-1:0];
			got.data      = m_tdata[M_DATA_LSB +: VAL_W];
			got.occupancy = m_tdata[M_OCC_LSB +: OCC_W];
			if (pending_results.size() == 0) begin
				note_fault($sformatf("result beat with nothing outstanding: status %0d data %0d occ %0d",
					got.status, $signed(got.data), got.occupancy));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					note_fault($sformatf("status expected %0d, got %0d", want.status, got.status));
				if (got.data !== want.data)
					note_fault($sformatf("data expected %0d, got %0d",
						$signed(want.data), $signed(got.data)));
				if (got.occupancy !== want.occupancy)
					note_fault($sformatf("occupancy expected %0d, got %0d",
						want.occupancy, got.occupancy));
			end
		end
	end

	initial begin : stimulus
		traffic_mode_t    kind;
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		int               sent;
		int               phase;
		int               phase_len;
		int               pick;
		logic             gaps_on;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].count,
				directed_rows[i].typed_in, directed_rows[i].want);
		settle();

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			// first phase fills past full, second empties it in one bulk beat
			if (phase == 0) begin
				kind = MODE_FILL;
				phase_len = DEPTH + 8;
			end else begin
				kind = (phase == 1) ? MODE_DRAIN : traffic_mode_t'($urandom_range(0, 3));
				phase_len = $urandom_range(20, 80);
			end
			gaps_on = $urandom_range(0, 2) != 0;

			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				quiet_tail = sent >= RANDOM_ITEMS - CALM_ITEMS;
				if (!quiet_tail && gaps_on && $urandom_range(0, 4) == 0)
					hold_off($urandom_range(1, 13));

				// operation by traffic mode
				pick = $urandom_range(0, 99);
				if (phase == 0) begin
					op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
				end else if (pick < 3) begin
					op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				end else begin
					case (kind)
						MODE_FILL:
							if (pick < 70)      op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
							else if (pick < 80) op = $urandom_range(0, 1) ? OP_PEEK_HEAD : OP_PEEK_TAIL;
							else if (pick < 90) op = OP_DEL_VALUE;
							else                op = $urandom_range(0, 1) ? OP_DEL_HEAD : OP_DEL_TAIL;
						MODE_DRAIN:
							if (pick < 50)      op = $urandom_range(0, 1) ? OP_DEL_HEAD : OP_DEL_TAIL;
							else if (pick < 70) op = $urandom_range(0, 1) ? OP_DEL_HEAD_N : OP_DEL_TAIL_N;
							else if (pick < 85) op = OP_DEL_VALUE;
							else if (pick < 95) op = $urandom_range(0, 1) ? OP_PEEK_HEAD : OP_PEEK_TAIL;
							else                op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
						MODE_SEARCH:
							if (pick < 45)      op = $urandom_range(0, 1) ? OP_INS_HEAD : OP_INS_TAIL;
							else if (pick < 85) op = OP_DEL_VALUE;
							else                op = $urandom_range(0, 1) ? OP_PEEK_HEAD : OP_PEEK_TAIL;
						default:
							op = OP_W'($urandom_range(OP_INS_HEAD, OP_DEL_VALUE));
					endcase
				end

				// value: wide random, a small pool for repeats, or the extremes
				pick = $urandom_range(0, 9);
				if (pick < 4)
					value = $urandom;
				else if (pick < 8 || (kind == MODE_SEARCH && op <= OP_INS_TAIL))
					value = $urandom_range(0, 8) - 4;
				else
					value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				// searches mostly aim at a value that is held
				if (op == OP_DEL_VALUE && fill_level > 0 && $urandom_range(0, 3) != 0)
					value = deque_store[slot_at($urandom_range(0, fill_level - 1))];

				// count: mostly within the current size for bulk deletes
				if ((op == OP_DEL_HEAD_N || op == OP_DEL_TAIL_N) && fill_level > 0
						&& $urandom_range(0, 3) != 0)
					count = CNT_W'($urandom_range(0, fill_level));
				else
					count = CNT_W'($urandom_range(0, DEPTH));
				if (phase == 1 && k == 0) begin
					op = $urandom_range(0, 1) ? OP_DEL_HEAD_N : OP_DEL_TAIL_N;
					count = CNT_W'(fill_level);
				end

				send_beat(op, value, count, 1'b0, '0);
				if (op <= OP_DEL_VALUE)
					sent++;
			end
			phase++;
			if (!quiet_tail)
				settle();
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// allow for a stray beat after the last expected one
		repeat (DEPTH + 4) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> bounded_deque_with_value_delete.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_deque_with_value_delete.sv
design/bdq_checker.sv
tb/testbench.sv
